### rtl/linear_resampler_two_to_three_assert.svh
// Assertion macros for the linear resampler, two inputs to three outputs.
`ifndef LINEAR_RESAMPLER_TWO_TO_THREE_ASSERT_SVH
`define LINEAR_RESAMPLER_TWO_TO_THREE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define LR23_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lr23 same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define LR23_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lr23 next-cycle check failed");

`endif

### rtl/lr23_pkg.sv
// Package: widths, types and constants of the linear resampler.
package lr23_pkg;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = SAMPLE_W + 1;
  localparam int unsigned PROD_W   = 2 * MAG_W;
  localparam int unsigned RECIP_SH = MAG_W;
  localparam logic [MAG_W-1:0] RECIP3 = MAG_W'(((1 << RECIP_SH) + 1) / 3);

  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_MID   = 2'd1;
  localparam logic [1:0] POS_LAST  = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]           mag_t;

  typedef struct packed {
    sample_t s0;
    sample_t s1;
    mag_t    mag_mid;
    logic    neg_mid;
    mag_t    mag_end;
    logic    neg_end;
  } job_t;

endpackage

### rtl/lr23_in_if.sv
// Interface: input sample channel.
interface lr23_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  left_sample;
  logic                end_of_stream;

  modport source (output valid, output left_sample, output end_of_stream, input ready);
  modport sink   (input valid, input left_sample, input end_of_stream, output ready);
endinterface

### rtl/lr23_out_if.sv
// Interface: resampled output channel.
interface lr23_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  out_sample;
  logic                last_of_run;

  modport source (output valid, output out_sample, output last_of_run, input ready);
  modport sink   (input valid, input out_sample, input last_of_run, output ready);
endinterface

### rtl/linear_resampler_two_to_three.sv
// Top level: 2-to-3 linear interpolation resampler.
//
// Input channel in_i carries a 32-bit left sample (top 16 bits used) and an
// end-of-stream flag; output channel out_o carries 16-bit samples, with
// last_of_run set on the third beat of every triple.
// Every second input beat (and an end-of-stream beat on the second sample of
// a pair) closes a pair and yields three output beats; other beats only load
// the held samples. An end-of-stream beat on an unpaired sample is dropped.
// The input beat that closes a pair loads the job register; the job then moves
// to the result buffer, from which the three beats of the triple are sent in order.
// Throughput: one input beat per cycle while the job register is empty or
// advancing; sustained rate is bounded by the output port at one beat per
// cycle. A job register and a three-entry result buffer decouple sides.
// Reset clears the pair phase and all valid flags; nothing is held.
// When the receiver stalls, the result buffer holds its beat, the job register
// fills, and in_i.ready drops once a further pair is waiting.
module linear_resampler_two_to_three
  import lr23_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  lr23_in_if.sink    in_i,
  lr23_out_if.source out_o
);

`include "linear_resampler_two_to_three_assert.svh"

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2
  } phase_e;

  phase_e  phase_q, phase_d;
  sample_t held_first_q, held_first_d;
  sample_t held_second_q, held_second_d;
  job_t    job_q, job_d;
  logic    job_v_q, job_v_d;
  sample_t buf_q [3];
  logic    ob_v_q;
  logic [1:0] pos_q;

  sample_t in_s;
  sample_t t_s0, t_s1, t_s2;
  logic    emit;
  logic    in_fire;
  logic    out_fire;
  logic    job_adv;
  logic signed [SAMPLE_W:0]   diff_mid;
  logic signed [SAMPLE_W+1:0] dbl_mid;
  logic signed [SAMPLE_W:0]   diff_end;
  logic signed [SAMPLE_W+1:0] abs_mid;
  logic signed [SAMPLE_W:0]   abs_end;
  sample_t res0, res1, res2;

  assign in_s     = in_i.left_sample[IN_W-1:IN_W-SAMPLE_W];
  assign out_fire = ob_v_q && out_o.ready;
  assign job_adv  = job_v_q && (!ob_v_q || (out_fire && pos_q == POS_LAST));
  assign in_i.ready = !job_v_q || job_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    phase_d       = phase_q;
    held_first_d  = held_first_q;
    held_second_d = held_second_q;
    emit          = 1'b0;
    t_s0          = held_first_q;
    t_s1          = in_s;
    t_s2          = in_s;
    case (phase_q)
      PH_ONE: begin
        if (in_i.end_of_stream) begin
          emit    = 1'b1;
          phase_d = PH_EMPTY;
        end else begin
          held_second_d = in_s;
          phase_d       = PH_TWO;
        end
      end
      PH_TWO: begin
        emit = 1'b1;
        t_s1 = held_second_q;
        if (in_i.end_of_stream) begin
          phase_d = PH_EMPTY;
        end else begin
          held_first_d = in_s;
          phase_d      = PH_ONE;
        end
      end
      default: begin
        if (in_i.end_of_stream) begin
          phase_d = PH_EMPTY;
        end else begin
          held_first_d = in_s;
          phase_d      = PH_ONE;
        end
      end
    endcase

    diff_mid = (SAMPLE_W+1)'(t_s1) - (SAMPLE_W+1)'(t_s0);
    dbl_mid  = (SAMPLE_W+2)'(diff_mid) <<< 1;
    diff_end = (SAMPLE_W+1)'(t_s2) - (SAMPLE_W+1)'(t_s1);
    abs_mid  = dbl_mid[SAMPLE_W+1] ? -dbl_mid : dbl_mid;
    abs_end  = diff_end[SAMPLE_W] ? -diff_end : diff_end;

    job_d.s0      = t_s0;
    job_d.s1      = t_s1;
    job_d.mag_mid = abs_mid[MAG_W-1:0];
    job_d.neg_mid = dbl_mid[SAMPLE_W+1];
    job_d.mag_end = abs_end[MAG_W-1:0];
    job_d.neg_end = diff_end[SAMPLE_W];

    job_v_d = job_v_q;
    if (in_fire && emit) begin
      job_v_d = 1'b1;
    end else if (job_adv) begin
      job_v_d = 1'b0;
    end
  end

  lr23_interp u_interp (
    .job_i  (job_q),
    .out0_o (res0),
    .out1_o (res1),
    .out2_o (res2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EMPTY;
      job_v_q <= 1'b0;
      ob_v_q  <= 1'b0;
      pos_q   <= POS_FIRST;
    end else begin
      job_v_q <= job_v_d;
      if (in_fire) begin
        phase_q <= phase_d;
      end
      if (job_adv) begin
        ob_v_q <= 1'b1;
        pos_q  <= POS_FIRST;
      end else if (out_fire) begin
        if (pos_q == POS_LAST) begin
          ob_v_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      held_first_q  <= held_first_d;
      held_second_q <= held_second_d;
    end
    if (in_fire && emit) begin
      job_q <= job_d;
    end
    if (job_adv) begin
      buf_q[0] <= res0;
      buf_q[1] <= res1;
      buf_q[2] <= res2;
    end
  end

  always_comb begin
    case (pos_q)
      POS_FIRST: out_o.out_sample = buf_q[0];
      POS_MID:   out_o.out_sample = buf_q[1];
      default:   out_o.out_sample = buf_q[2];
    endcase
  end

  assign out_o.valid       = ob_v_q;
  assign out_o.last_of_run = (pos_q == POS_LAST);

  `LR23_ASSERT_NEXT(a_pair_loads_job, clk_i, rst_ni,
                    in_fire && phase_q == PH_TWO, job_v_q)
  `LR23_ASSERT_NEXT(a_job_starts_triple, clk_i, rst_ni,
                    job_adv, ob_v_q && pos_q == POS_FIRST)
  `LR23_ASSERT_NEXT(a_last_beat_drains, clk_i, rst_ni,
                    out_fire && pos_q == POS_LAST && !job_v_q, !ob_v_q)
  `LR23_ASSERT_SAME(a_pos_in_range, clk_i, rst_ni,
                    ob_v_q, pos_q == POS_FIRST || pos_q == POS_MID || pos_q == POS_LAST)

endmodule

### rtl/lr23_interp.sv
// Interpolator: divide-by-three by reciprocal and the three samples of a triple.
module lr23_interp
  import lr23_pkg::*;
(
  input  job_t    job_i,
  output sample_t out0_o,
  output sample_t out1_o,
  output sample_t out2_o
);

  logic [PROD_W-1:0]   prod_mid;
  logic [PROD_W-1:0]   prod_end;
  mag_t                quo_mid;
  mag_t                quo_end;
  logic signed [MAG_W:0] step_mid;
  logic signed [MAG_W:0] step_end;
  logic signed [MAG_W:0] sum_mid;
  logic signed [MAG_W:0] sum_end;

  always_comb begin
    prod_mid = PROD_W'(job_i.mag_mid) * PROD_W'(RECIP3);
    prod_end = PROD_W'(job_i.mag_end) * PROD_W'(RECIP3);
    quo_mid  = prod_mid[PROD_W-1:RECIP_SH];
    quo_end  = prod_end[PROD_W-1:RECIP_SH];
    step_mid = job_i.neg_mid ? -$signed({1'b0, quo_mid}) : $signed({1'b0, quo_mid});
    step_end = job_i.neg_end ? -$signed({1'b0, quo_end}) : $signed({1'b0, quo_end});
    sum_mid  = (MAG_W+1)'(job_i.s0) + step_mid;
    sum_end  = (MAG_W+1)'(job_i.s1) + step_end;
  end

  assign out0_o = job_i.s0;
  assign out1_o = sum_mid[SAMPLE_W-1:0];
  assign out2_o = sum_end[SAMPLE_W-1:0];

endmodule
